// ----- rtl/eftc_pkg.sv -----
`default_nettype none

package eftc_pkg;

    // Input beat operation codes
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

endpackage

`default_nettype wire

// ----- rtl/eftc_if.sv -----
`default_nettype none

interface eftc_in_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic signed [COORD_BITS-1:0] vert_a_x;
    logic signed [COORD_BITS-1:0] vert_a_y;
    logic signed [COORD_BITS-1:0] vert_b_x;
    logic signed [COORD_BITS-1:0] vert_b_y;
    logic signed [COORD_BITS-1:0] vert_c_x;
    logic signed [COORD_BITS-1:0] vert_c_y;
    logic [31:0]                  fill_color;

    modport source (
        output valid, op, vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y,
               fill_color,
        input  ready
    );
    modport sink (
        input  valid, op, vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y,
               fill_color,
        output ready
    );
endinterface

interface eftc_out_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         inside_res;
    logic [31:0]                  pixel_color;
    logic                         last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, inside_res, pixel_color, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, inside_res, pixel_color, last_pixel,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/edge_function_triangle_coverage_unit.sv -----
`default_nettype none

// Channel  | Modport      | Beat
// ---------+--------------+--------------------------------------------------
// i_item   | sink         | op, three vertices, fill_color (load or step)
// o_pixel  | source       | pixel_x, pixel_y, inside_res, pixel_color, last_pixel
//
// One beat is taken per cycle while the result register is not stalled; a step
// beat's pixel passes through the input register, then edge evaluation into the
// result register.
// Load beats and steps with no triangle left give no pixel.
// Reset (synchronous, active low) empties both registers and ends any scan.
// A stalled result holds the pipe; i_item.ready drops only when the input
// register is full and the result register is waiting on o_pixel.ready.
module edge_function_triangle_coverage_unit
    import eftc_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    eftc_in_if.sink     i_item,
    eftc_out_if.source  o_pixel
);

    localparam int CB = COORD_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int EW = 2 * DW + 1;

    // Input register
    logic                 r_in_v;
    logic                 r_op;
    logic signed [CB-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic [31:0]          r_fill;

    // Triangle and scan state
    logic signed [CB-1:0] r_vx [3];
    logic signed [CB-1:0] r_vy [3];
    logic signed [CB-1:0] r_xmin, r_xmax, r_ymax, r_sx, r_sy;
    logic [31:0]          r_color;
    logic                 r_active;

    // Result register
    logic                 r_out_v;
    logic signed [CB-1:0] r_px, r_py;
    logic                 r_inside;
    logic [31:0]          r_pcolor;
    logic                 r_last;

    logic stall, advance, do_load, do_step;

    assign stall        = r_out_v && !o_pixel.ready;
    assign advance      = r_in_v && !stall;
    assign do_load      = advance && (r_op == OP_LOAD);
    assign do_step      = advance && (r_op == OP_STEP) && r_active;
    assign i_item.ready = !r_in_v || !stall;

    function automatic logic signed [CB-1:0] min3(input logic signed [CB-1:0] a,
                                                  input logic signed [CB-1:0] b,
                                                  input logic signed [CB-1:0] c);
        logic signed [CB-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [CB-1:0] max3(input logic signed [CB-1:0] a,
                                                  input logic signed [CB-1:0] b,
                                                  input logic signed [CB-1:0] c);
        logic signed [CB-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Degeneracy test on the loaded vertices
    logic signed [DW-1:0] dg_ux, dg_uy, dg_vx, dg_vy;
    logic signed [EW-1:0] dg_w;

    assign dg_ux = DW'(r_bx) - DW'(r_ax);
    assign dg_uy = DW'(r_by) - DW'(r_ay);
    assign dg_vx = DW'(r_cx) - DW'(r_ax);
    assign dg_vy = DW'(r_cy) - DW'(r_ay);

    eftc_edge #(.DIFF_BITS(DW)) u_edge_dg (
        .i_ux(dg_ux), .i_uy(dg_uy), .i_vx(dg_vx), .i_vy(dg_vy), .o_w(dg_w)
    );

    // Edge functions of each triangle edge at the current scan position
    logic signed [DW-1:0] e_ux [3];
    logic signed [DW-1:0] e_uy [3];
    logic signed [DW-1:0] e_vx [3];
    logic signed [DW-1:0] e_vy [3];
    logic signed [EW-1:0] e_w  [3];

    always_comb begin
        e_ux[0] = DW'(r_vx[2]) - DW'(r_vx[1]);
        e_uy[0] = DW'(r_vy[2]) - DW'(r_vy[1]);
        e_vx[0] = DW'(r_sx)    - DW'(r_vx[1]);
        e_vy[0] = DW'(r_sy)    - DW'(r_vy[1]);
        e_ux[1] = DW'(r_vx[0]) - DW'(r_vx[2]);
        e_uy[1] = DW'(r_vy[0]) - DW'(r_vy[2]);
        e_vx[1] = DW'(r_sx)    - DW'(r_vx[2]);
        e_vy[1] = DW'(r_sy)    - DW'(r_vy[2]);
        e_ux[2] = DW'(r_vx[1]) - DW'(r_vx[0]);
        e_uy[2] = DW'(r_vy[1]) - DW'(r_vy[0]);
        e_vx[2] = DW'(r_sx)    - DW'(r_vx[0]);
        e_vy[2] = DW'(r_sy)    - DW'(r_vy[0]);
    end

    for (genvar g = 0; g < 3; g++) begin : g_edge
        eftc_edge #(.DIFF_BITS(DW)) u_edge (
            .i_ux(e_ux[g]), .i_uy(e_uy[g]), .i_vx(e_vx[g]), .i_vy(e_vy[g]),
            .o_w(e_w[g])
        );
    end

    logic n_inside, n_last;
    logic neg0, neg1, neg2, zer0, zer1, zer2;

    always_comb begin
        neg0     = e_w[0][EW-1];
        neg1     = e_w[1][EW-1];
        neg2     = e_w[2][EW-1];
        zer0     = (e_w[0] == '0);
        zer1     = (e_w[1] == '0);
        zer2     = (e_w[2] == '0);
        n_inside = (!neg0 && !neg1 && !neg2) ||
                   ((neg0 || zer0) && (neg1 || zer1) && (neg2 || zer2));
        n_last   = (r_sx == r_xmax) && (r_sy == r_ymax);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v   <= 1'b0;
            r_out_v  <= 1'b0;
            r_active <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_v <= i_item.valid;
            end
            if (do_step) begin
                r_out_v <= 1'b1;
            end else if (o_pixel.ready) begin
                r_out_v <= 1'b0;
            end
            if (do_load) begin
                r_active <= (dg_w != '0);
            end else if (do_step && n_last) begin
                r_active <= 1'b0;
            end
        end
    end

    // Payload and triangle registers
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_op   <= i_item.op;
            r_ax   <= i_item.vert_a_x;
            r_ay   <= i_item.vert_a_y;
            r_bx   <= i_item.vert_b_x;
            r_by   <= i_item.vert_b_y;
            r_cx   <= i_item.vert_c_x;
            r_cy   <= i_item.vert_c_y;
            r_fill <= i_item.fill_color;
        end
        if (do_load) begin
            r_vx[0] <= r_ax;
            r_vx[1] <= r_bx;
            r_vx[2] <= r_cx;
            r_vy[0] <= r_ay;
            r_vy[1] <= r_by;
            r_vy[2] <= r_cy;
            r_color <= r_fill;
            r_xmin  <= min3(r_ax, r_bx, r_cx);
            r_xmax  <= max3(r_ax, r_bx, r_cx);
            r_ymax  <= max3(r_ay, r_by, r_cy);
            r_sx    <= min3(r_ax, r_bx, r_cx);
            r_sy    <= min3(r_ay, r_by, r_cy);
        end else if (do_step && !n_last) begin
            // advance row-major; wrap to the left edge at the end of a row
            if (r_sx >= r_xmax) begin
                r_sx <= r_xmin;
                r_sy <= r_sy + CB'(1);
            end else begin
                r_sx <= r_sx + CB'(1);
            end
        end
        if (do_step) begin
            r_px     <= r_sx;
            r_py     <= r_sy;
            r_inside <= n_inside;
            r_pcolor <= r_color;
            r_last   <= n_last;
        end
    end

    assign o_pixel.valid       = r_out_v;
    assign o_pixel.pixel_x     = r_px;
    assign o_pixel.pixel_y     = r_py;
    assign o_pixel.inside_res  = r_inside;
    assign o_pixel.pixel_color = r_pcolor;
    assign o_pixel.last_pixel  = r_last;

endmodule

`default_nettype wire

// ----- rtl/eftc_edge.sv -----
`default_nettype none

// Edge function: cross product ux*vy - uy*vx of two signed difference vectors
module eftc_edge #(
    parameter int DIFF_BITS = 13
) (
    input  wire logic signed [DIFF_BITS-1:0] i_ux,
    input  wire logic signed [DIFF_BITS-1:0] i_uy,
    input  wire logic signed [DIFF_BITS-1:0] i_vx,
    input  wire logic signed [DIFF_BITS-1:0] i_vy,
    output logic signed [2*DIFF_BITS:0]      o_w
);

    logic signed [2*DIFF_BITS-1:0] prod_a;
    logic signed [2*DIFF_BITS-1:0] prod_b;

    assign prod_a = i_ux * i_vy;
    assign prod_b = i_uy * i_vx;
    assign o_w    = (2*DIFF_BITS+1)'(prod_a) - (2*DIFF_BITS+1)'(prod_b);

endmodule

`default_nettype wire

// ----- rtl/eftc_checker.sv -----
`default_nettype none

module eftc_checker
    import eftc_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_in_op,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_last
);

    // A waiting pixel beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("pixel beat dropped while stalled");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("pixel beat present after reset");

    // A fresh pixel only follows an accepted step beat, by way of the input and result registers
    a_rise_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && (i_in_op == OP_STEP), 2))
        else $error("pixel beat without a step beat");

    // The last pixel of a box is followed by a gap
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_last |=> !i_out_valid)
        else $error("pixel beat straight after the last pixel");

endmodule

bind edge_function_triangle_coverage_unit eftc_checker u_eftc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_op     (i_item.op),
    .i_out_valid (o_pixel.valid),
    .i_out_ready (o_pixel.ready),
    .i_out_last  (o_pixel.last_pixel)
);

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import eftc_pkg::*;

    localparam int CW          = 12;
    localparam int BEAT_TARGET = 1725;
    localparam int HOLD_FROM   = 600;
    localparam int HOLD_TO     = 1000;
    localparam int TAIL_CYCLES = 8;
    localparam int LIMIT_NS    = 2_000_000;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct {
        t_op         op;
        t_coord      ax, ay, bx, by, cx, cy;
        logic [31:0] color;
    } t_tri_beat;

    typedef struct {
        t_coord      x, y;
        logic        covered;
        logic [31:0] color;
        logic        last;
    } t_pixel;

    logic i_clk;
    logic i_rst_n;

    eftc_in_if  #(.COORD_BITS(CW)) in_if ();
    eftc_out_if #(.COORD_BITS(CW)) out_if ();

    edge_function_triangle_coverage_unit #(
        .COORD_BITS(CW)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (in_if),
        .o_pixel (out_if)
    );

    t_tri_beat beat_q[$];
    t_pixel    pixel_q[$];
    t_tri_beat nxt_hold;
    int        beats_taken = 0;
    int        total_beats = 0;
    int        err_cnt     = 0;
    int        run_cyc     = 0;
    logic      long_hold;

    // scan state kept alongside the block
    t_coord      tri_x[3], tri_y[3];
    t_coord      box_xlo, box_xhi, box_yhi;
    t_coord      scan_px, scan_py;
    logic [31:0] fill_held;
    bit          scanning = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint cross2(longint ux, longint uy, longint vx, longint vy);
        return ux * vy - uy * vx;
    endfunction

    function automatic t_coord lo3(t_coord a, t_coord b, t_coord c);
        t_coord m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic t_coord hi3(t_coord a, t_coord b, t_coord c);
        t_coord m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // 0: sender 20 / receiver 62, 1: swapped, 2: no idling
    function automatic int idle_phase();
        if (beats_taken < total_beats / 3)
            return 0;
        else if (beats_taken < (2 * total_beats) / 3)
            return 1;
        return 2;
    endfunction

    task automatic rasterise_beat(input t_tri_beat b);
        longint w0, w1, w2;
        t_pixel p;
        if (b.op == OP_LOAD) begin
            tri_x[0] = b.ax; tri_y[0] = b.ay;
            tri_x[1] = b.bx; tri_y[1] = b.by;
            tri_x[2] = b.cx; tri_y[2] = b.cy;
            fill_held = b.color;
            box_xlo = lo3(tri_x[0], tri_x[1], tri_x[2]);
            box_xhi = hi3(tri_x[0], tri_x[1], tri_x[2]);
            box_yhi = hi3(tri_y[0], tri_y[1], tri_y[2]);
            scan_px = box_xlo;
            scan_py = lo3(tri_y[0], tri_y[1], tri_y[2]);
            scanning = cross2(longint'(tri_x[1]) - longint'(tri_x[0]),
                              longint'(tri_y[1]) - longint'(tri_y[0]),
                              longint'(tri_x[2]) - longint'(tri_x[0]),
                              longint'(tri_y[2]) - longint'(tri_y[0])) != 0;
            return;
        end
        if (!scanning)
            return;
        w0 = cross2(longint'(tri_x[2]) - longint'(tri_x[1]),
                    longint'(tri_y[2]) - longint'(tri_y[1]),
                    longint'(scan_px) - longint'(tri_x[1]),
                    longint'(scan_py) - longint'(tri_y[1]));
        w1 = cross2(longint'(tri_x[0]) - longint'(tri_x[2]),
                    longint'(tri_y[0]) - longint'(tri_y[2]),
                    longint'(scan_px) - longint'(tri_x[2]),
                    longint'(scan_py) - longint'(tri_y[2]));
        w2 = cross2(longint'(tri_x[1]) - longint'(tri_x[0]),
                    longint'(tri_y[1]) - longint'(tri_y[0]),
                    longint'(scan_px) - longint'(tri_x[0]),
                    longint'(scan_py) - longint'(tri_y[0]));
        p.x       = scan_px;
        p.y       = scan_py;
        p.covered = (w0 >= 0 && w1 >= 0 && w2 >= 0) || (w0 <= 0 && w1 <= 0 && w2 <= 0);
        p.color   = fill_held;
        p.last    = (scan_px == box_xhi) && (scan_py == box_yhi);
        pixel_q.push_back(p);
        if (p.last) begin
            scanning = 1'b0;
        end else if (scan_px >= box_xhi) begin
            scan_px = box_xlo;
            scan_py = scan_py + t_coord'(1);
        end else begin
            scan_px = scan_px + t_coord'(1);
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (err_cnt < 50)
            $display("[%0t] mismatch %s: got %h, want %h", $time, what, got, want);
        err_cnt++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_mismatch(what, got, want);
    endtask

    task automatic add_load(input int ax, ay, bx, by, cx, cy, input logic [31:0] color);
        t_tri_beat b;
        b.op = OP_LOAD;
        b.ax = CW'(ax); b.ay = CW'(ay);
        b.bx = CW'(bx); b.by = CW'(by);
        b.cx = CW'(cx); b.cy = CW'(cy);
        b.color = color;
        beat_q.push_back(b);
    endtask

    // step beats carry junk in the vertex fields; the block must ignore it
    task automatic add_steps(input int n);
        t_tri_beat b;
        repeat (n) begin
            b.op = OP_STEP;
            b.ax = CW'($urandom); b.ay = CW'($urandom);
            b.bx = CW'($urandom); b.by = CW'($urandom);
            b.cx = CW'($urandom); b.cy = CW'($urandom);
            b.color = $urandom;
            beat_q.push_back(b);
        end
    endtask

    task automatic add_small_triangle();
        int sx, sy, ox, oy, ax, ay, bx, by, cx, cy, area, n;
        sx = ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 7);
        sy = ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 7);
        ox = int'($urandom_range(4095 - sx)) - 2048;
        oy = int'($urandom_range(4095 - sy)) - 2048;
        ax = ox + $urandom_range(sx); ay = oy + $urandom_range(sy);
        bx = ox + $urandom_range(sx); by = oy + $urandom_range(sy);
        cx = ox + $urandom_range(sx); cy = oy + $urandom_range(sy);
        area = ((ax > bx ? (ax > cx ? ax : cx) : (bx > cx ? bx : cx)) -
                (ax < bx ? (ax < cx ? ax : cx) : (bx < cx ? bx : cx)) + 1) *
               ((ay > by ? (ay > cy ? ay : cy) : (by > cy ? by : cy)) -
                (ay < by ? (ay < cy ? ay : cy) : (by < cy ? by : cy)) + 1);
        add_load(ax, ay, bx, by, cx, cy, $urandom);
        // mostly scan the whole box, at times past its end; sometimes cut it short
        if ($urandom_range(99) < 15)
            n = $urandom_range(1, area);
        else
            n = area + $urandom_range(0, 3);
        add_steps(n);
    endtask

    task automatic add_degenerate();
        int ax, ay, dx, dy, k1, k2;
        ax = int'($urandom_range(4083)) - 2042;
        ay = int'($urandom_range(4083)) - 2042;
        dx = int'($urandom_range(6)) - 3;
        dy = int'($urandom_range(6)) - 3;
        k1 = $urandom_range(2);
        k2 = $urandom_range(2);
        add_load(ax, ay, ax + k1 * dx, ay + k1 * dy, ax + k2 * dx, ay + k2 * dy, $urandom);
        add_steps($urandom_range(1, 3));
    endtask

    task automatic add_wide_triangle();
        add_load(int'(CW'($urandom)), int'(CW'($urandom)), int'(CW'($urandom)),
                 int'(CW'($urandom)), int'(CW'($urandom)), int'(CW'($urandom)), $urandom);
        add_steps($urandom_range(1, 10));
    endtask

    // driver
    always @(posedge i_clk) begin
        t_tri_beat nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                rasterise_beat(nxt_hold);
                beats_taken++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (beat_q.size() != 0 &&
                    $urandom_range(99) >= (idle_phase() == 0 ? 20 :
                                           idle_phase() == 1 ? 62 : 0)) begin
                    nxt = beat_q.pop_front();
                    nxt_hold = nxt;
                    in_if.op         <= nxt.op;
                    in_if.vert_a_x   <= nxt.ax;
                    in_if.vert_a_y   <= nxt.ay;
                    in_if.vert_b_x   <= nxt.bx;
                    in_if.vert_b_y   <= nxt.by;
                    in_if.vert_c_x   <= nxt.cx;
                    in_if.vert_c_y   <= nxt.cy;
                    in_if.fill_color <= nxt.color;
                    in_if.valid      <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver stall counter
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            run_cyc <= 0;
        end else begin
            run_cyc <= run_cyc + 1;
        end
    end

    assign long_hold = (run_cyc >= HOLD_FROM) && (run_cyc < HOLD_TO);

    // monitor
    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (pixel_q.size() == 0) begin
                    flag_mismatch("pixel beat with nothing pending", 32'(out_if.pixel_x),
                                  32'(out_if.pixel_y));
                end else begin
                    want = pixel_q.pop_front();
                    check_field("pixel_x", 32'(out_if.pixel_x), 32'(want.x));
                    check_field("pixel_y", 32'(out_if.pixel_y), 32'(want.y));
                    check_field("inside_res", 32'(out_if.inside_res), 32'(want.covered));
                    check_field("pixel_color", out_if.pixel_color, want.color);
                    check_field("last_pixel", 32'(out_if.last_pixel), 32'(want.last));
                end
            end
            if (long_hold)
                out_if.ready <= 1'b0;
            else
                out_if.ready <= $urandom_range(99) >= (idle_phase() == 0 ? 62 :
                                                       idle_phase() == 1 ? 20 : 0);
        end
    end

    initial begin
        int pick;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.op         = OP_LOAD;
        in_if.vert_a_x   = '0;
        in_if.vert_a_y   = '0;
        in_if.vert_b_x   = '0;
        in_if.vert_b_y   = '0;
        in_if.vert_c_x   = '0;
        in_if.vert_c_y   = '0;
        in_if.fill_color = '0;
        out_if.ready     = 1'b0;

        // steps before any triangle is loaded
        add_steps(2);
        // all three vertices on one point, then on one long diagonal
        add_load(0, 0, 0, 0, 0, 0, 32'h0000_0000);
        add_steps(1);
        add_load(-2048, -2048, 0, 0, 2047, 2047, 32'hFFFF_FFFF);
        add_steps(1);
        // top corner of the screen, full box and one step past its end
        add_load(2047, 2047, 2045, 2047, 2047, 2045, 32'hA5A5_5A5A);
        add_steps(10);
        // opposite winding at the bottom corner, cut short by the next load
        add_load(-2048, -2048, -2048, -2046, -2046, -2048, 32'h5A5A_A5A5);
        add_steps(4);
        add_load(-2048, 2047, 2047, 2047, 0, -2048, 32'h1234_5678);
        add_steps(3);

        while (beat_q.size() < BEAT_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 70)
                add_small_triangle();
            else if (pick < 80)
                add_degenerate();
            else if (pick < 90)
                add_wide_triangle();
            else
                add_steps($urandom_range(1, 4));
        end
        total_beats = beat_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_taken < total_beats)
            @(posedge i_clk);
        while (pixel_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule
